[src/kcl_pkg.sv]
// Package for the keypad code lock: key codes, event codes, pass codes,
// widths and the result struct shared by the core and the top level.
// No dependencies.
package kcl_pkg;

	localparam int CODE_LENGTH_DEF = 10;
	localparam int KEY_W = 4;
	localparam int PLACE_W = 4;
	localparam int FAIL_W = 4;
	localparam int SAVED_W = 40;

	localparam logic [PLACE_W-1:0] BLANK_PLACE = 4'hF;
	localparam logic [KEY_W-1:0] KEY_ENTER = 4'd10;
	localparam logic [KEY_W-1:0] KEY_CHANGE = 4'd11;
	localparam logic [FAIL_W-1:0] MAX_FAILS = 4'd15;
	localparam logic [FAIL_W-1:0] THRESHOLD_RESET = 4'd3;

	typedef enum logic [3:0] {
		EV_DIGIT = 4'd0,
		EV_WRONG = 4'd1,
		EV_WRONG_ALARM = 4'd2,
		EV_UNLOCKED = 4'd3,
		EV_CHANGE_BEGUN = 4'd4,
		EV_FIRST_DONE = 4'd5,
		EV_CHANGE_OK = 4'd6,
		EV_CHANGE_FAILED = 4'd7,
		EV_CANCELLED = 4'd8,
		EV_IGNORED = 4'd9
	} kcl_event_t;

	typedef enum logic [1:0] {
		PASS_NONE = 2'd0,
		PASS_FIRST = 2'd1,
		PASS_CONFIRM = 2'd2
	} kcl_pass_t;

	typedef struct packed {
		kcl_event_t ev;
		logic door_open;
		logic close_door;
		logic change_mode;
		kcl_pass_t entry_pass;
		logic [FAIL_W-1:0] fail_count;
		logic [SAVED_W-1:0] saved_code;
	} kcl_result_t;

endpackage

[src/kcl_core.sv]
// Lock state and per-key update logic of the keypad code lock.
// Holds the code registers, door, change and failure state; depends on kcl_pkg.
module kcl_core import kcl_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [KEY_W-1:0] key,
	input logic [FAIL_W-1:0] threshold,
	output kcl_result_t result
);

	localparam int CODE_W = CODE_LENGTH * PLACE_W;
	localparam logic [CODE_W-1:0] BLANK_CODE = {CODE_LENGTH{BLANK_PLACE}};

	logic [CODE_W-1:0] entry_q, first_q, confirm_q, stored_q;
	logic [CODE_W-1:0] entry_d, first_d, confirm_d, stored_d;
	logic open_q, open_d;
	logic in_change_q, in_change_d;
	kcl_pass_t pass_q, pass_d;
	logic [FAIL_W-1:0] fail_q, fail_d, fail_inc;
	logic [SAVED_W-1:0] first_packed;
	kcl_event_t ev;
	logic close;
	logic save;

	// Newest place sits in the low nibble; keep only the low SAVED_W bits, zero-extending a shorter code.
	if (CODE_W >= SAVED_W) begin : g_saved_trunc
		assign first_packed = first_q[SAVED_W-1:0];
	end else begin : g_saved_ext
		assign first_packed = {{(SAVED_W-CODE_W){1'b0}}, first_q};
	end

	assign fail_inc = (fail_q < MAX_FAILS) ? fail_q + 1'b1 : fail_q;

	always_comb begin
		entry_d = entry_q;
		first_d = first_q;
		confirm_d = confirm_q;
		stored_d = stored_q;
		open_d = open_q;
		in_change_d = in_change_q;
		pass_d = pass_q;
		fail_d = fail_q;
		ev = EV_IGNORED;
		close = 1'b0;
		save = 1'b0;
		if (key <= KEY_CHANGE) begin
			if (!in_change_q) begin
				if (!open_q && key < KEY_ENTER) begin
					entry_d = {entry_q[CODE_W-PLACE_W-1:0], key};
					ev = EV_DIGIT;
				end else if (!open_q && key == KEY_ENTER) begin
					if (entry_q == stored_q) begin
						open_d = 1'b1;
						fail_d = '0;
						ev = EV_UNLOCKED;
					end else begin
						fail_d = fail_inc;
						ev = (fail_inc >= threshold) ? EV_WRONG_ALARM : EV_WRONG;
					end
					// every check leaves a blank entry
					entry_d = BLANK_CODE;
				end else if (open_q && key == KEY_CHANGE) begin
					entry_d = BLANK_CODE;
					first_d = BLANK_CODE;
					confirm_d = BLANK_CODE;
					in_change_d = 1'b1;
					pass_d = PASS_FIRST;
					ev = EV_CHANGE_BEGUN;
				end
			end else if (key == KEY_CHANGE) begin
				in_change_d = 1'b0;
				open_d = 1'b0;
				pass_d = PASS_NONE;
				entry_d = BLANK_CODE;
				first_d = BLANK_CODE;
				confirm_d = BLANK_CODE;
				close = 1'b1;
				ev = EV_CANCELLED;
			end else if (pass_q == PASS_FIRST) begin
				if (key < KEY_ENTER) begin
					first_d = {first_q[CODE_W-PLACE_W-1:0], key};
					ev = EV_DIGIT;
				end else begin
					pass_d = PASS_CONFIRM;
					ev = EV_FIRST_DONE;
				end
			end else if (pass_q == PASS_CONFIRM) begin
				if (key < KEY_ENTER) begin
					confirm_d = {confirm_q[CODE_W-PLACE_W-1:0], key};
					ev = EV_DIGIT;
				end else begin
					if (first_q == confirm_q) begin
						stored_d = first_q;
						save = 1'b1;
						ev = EV_CHANGE_OK;
					end else begin
						ev = EV_CHANGE_FAILED;
					end
					in_change_d = 1'b0;
					open_d = 1'b0;
					pass_d = PASS_NONE;
					first_d = BLANK_CODE;
					confirm_d = BLANK_CODE;
					close = 1'b1;
				end
			end
		end
	end

	always_comb begin
		result.ev = ev;
		result.door_open = open_d;
		result.close_door = close;
		result.change_mode = in_change_d;
		result.entry_pass = pass_d;
		result.fail_count = fail_d;
		result.saved_code = save ? first_packed : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= BLANK_CODE;
			first_q <= BLANK_CODE;
			confirm_q <= BLANK_CODE;
			stored_q <= BLANK_CODE;
			open_q <= 1'b0;
			in_change_q <= 1'b0;
			pass_q <= PASS_NONE;
			fail_q <= '0;
		end else if (step) begin
			entry_q <= entry_d;
			first_q <= first_d;
			confirm_q <= confirm_d;
			stored_q <= stored_d;
			open_q <= open_d;
			in_change_q <= in_change_d;
			pass_q <= pass_d;
			fail_q <= fail_d;
		end
	end

	a_change_has_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_change_q |-> (pass_q == PASS_FIRST || pass_q == PASS_CONFIRM))
		else $error("change mode without an entry pass");

	a_idle_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!in_change_q |-> pass_q == PASS_NONE)
		else $error("entry pass set outside change mode");

	a_change_door_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_change_q |-> open_q)
		else $error("change mode with the door locked");

	a_unlock_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.ev == EV_UNLOCKED) |=> (open_q && fail_q == '0))
		else $error("unlock did not open the door or clear failures");

	a_close_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(step && result.close_door) |=> (!open_q && !in_change_q))
		else $error("close request left the door open or change active");

endmodule

[src/keypad_code_lock.sv]
// Keypad code lock top level: input register, lock core and result register.
// Depends on kcl_pkg and kcl_core.
//
// Usage: one key code per word arrives on key with key_valid; the block
// holds it off with key_stall. Each key gives exactly one result word on
// event_res, door_open, close_door, change_mode, entry_pass, fail_count and
// saved_code, qualified by res_valid and held off by res_stall.
// A word is taken at a rising edge with valid high and stall low.
// Throughput: one key per cycle while res_stall is low; the lock state is
// updated by the compare and shift logic between the input and result
// registers. While res_stall holds a waiting result, the key in the input
// register waits too and key_stall rises; nothing is dropped. The user must
// write alarm_threshold with alarm_threshold_we only while the block is
// idle; the block itself does not enforce this. Reset clears both pipeline
// stages, blanks all code registers, locks the door, clears the failure
// count and sets the threshold to 3.
module keypad_code_lock import kcl_pkg::*; #(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic alarm_threshold_we,
	input logic [FAIL_W-1:0] alarm_threshold,
	input logic key_valid,
	output logic key_stall,
	input logic [KEY_W-1:0] key,
	output logic res_valid,
	input logic res_stall,
	output logic [3:0] event_res,
	output logic door_open,
	output logic close_door,
	output logic change_mode,
	output logic [1:0] entry_pass,
	output logic [FAIL_W-1:0] fail_count,
	output logic [SAVED_W-1:0] saved_code
);

	logic [FAIL_W-1:0] threshold_q;
	logic [KEY_W-1:0] key_s1;
	logic valid_s1;
	logic valid_s2;
	kcl_result_t result_s2;
	kcl_result_t result;
	logic advance;
	logic step;

	// advance when the result register is empty or being taken
	assign advance = !valid_s2 || !res_stall;
	assign step = valid_s1 && advance;
	assign key_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (alarm_threshold_we) begin
			threshold_q <= alarm_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!key_stall) begin
			valid_s1 <= key_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!key_stall && key_valid) begin
			key_s1 <= key;
		end
	end

	kcl_core #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.key(key_s1),
		.threshold(threshold_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign res_valid = valid_s2;
	assign event_res = result_s2.ev;
	assign door_open = result_s2.door_open;
	assign close_door = result_s2.close_door;
	assign change_mode = result_s2.change_mode;
	assign entry_pass = result_s2.entry_pass;
	assign fail_count = result_s2.fail_count;
	assign saved_code = result_s2.saved_code;

endmodule
